// ===== sv/itoa_pkg.sv =====
// Package for the signed integer to decimal ASCII formatter.
// Holds widths, character codes, the cell control struct and the FSM states.
// No dependencies; used by itoa_cell and signed_int_to_decimal_ascii.
package itoa_pkg;

  // Width of the input port, fixed by the interface.
  localparam int IN_BITS = 32;

  // Width of the formatted integer; bit VALUE_BITS-1 is the sign (8..64).
  localparam int VALUE_BITS = 32;

  // BCD digit cells: decimal digits of 2^VALUE_BITS, rounded up
  // (log10(2) ~ 0.30103).
  localparam int NUM_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DIG_W = $clog2(NUM_DIGITS + 1);

  localparam logic [6:0] DIGIT_BASE = 7'd48;
  localparam logic [6:0] MINUS_CODE = 7'd45;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;
  localparam logic [3:0] BCD_MAX = 4'd9;

  // Control shared by every cell in the chain.
  typedef struct packed {
    logic clr;   // clear digit at start of a transaction
    logic conv;  // one shift-add-3 step
    logic emit;  // move digits one place toward the top cell
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

endpackage

// ===== sv/itoa_cell.sv =====
// One BCD digit cell of the double-dabble chain.
// Depends on itoa_pkg (cell_ctrl_t and BCD constants).
module itoa_cell (
  input  logic                 clk_i,
  input  itoa_pkg::cell_ctrl_t ctrl_i,
  input  logic                 conv_in_i,  // bit shifted in from lower cell
  output logic                 conv_out_o, // bit shifted out to upper cell
  input  logic [3:0]           dig_in_i,   // lower cell's digit, emit shift
  output logic [3:0]           dig_o
);

  logic [3:0] dig_q;
  logic [3:0] adj;

  always_comb begin
    adj = (dig_q >= itoa_pkg::BCD_ADJ_MIN) ? (dig_q + itoa_pkg::BCD_ADJ_ADD) : dig_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      dig_q <= 4'd0;
    end else if (ctrl_i.conv) begin
      dig_q <= {adj[2:0], conv_in_i};
    end else if (ctrl_i.emit) begin
      dig_q <= dig_in_i;
    end
  end

  assign conv_out_o = adj[3];
  assign dig_o      = dig_q;

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// After accept, the magnitude shifts one bit per cycle through the BCD cell chain
// (ST_CONV), leading zeros are dropped (ST_SKIP), then the sign (ST_SIGN, if
// negative) and the digits (ST_EMIT) go out, one character per output transaction.
// Output stalls hold ST_SIGN and ST_EMIT; a new value is accepted only in idle.
// Reset (rst_ni low, asynchronous) returns the FSM to idle and drops out_valid_o.
// Depends on itoa_pkg and itoa_cell.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic signed [itoa_pkg::IN_BITS-1:0] value_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  // output channel, one transaction per character
  output logic [6:0]  character_o,
  output logic        last_char_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  localparam int VB = itoa_pkg::VALUE_BITS;
  localparam int ND = itoa_pkg::NUM_DIGITS;
  localparam int WIDE = 64 + itoa_pkg::IN_BITS;

  itoa_pkg::state_e state_q, state_d;

  logic [VB-1:0]              mag_q;   // magnitude, shifted out MSB first
  logic                       neg_q;
  logic [itoa_pkg::CNT_W-1:0] cnt_q;   // conversion steps left
  logic [itoa_pkg::DIG_W-1:0] left_q;  // digits still in the chain

  logic [6:0] char_q, char_d;
  logic       last_q, last_d;
  logic       valid_q;
  logic       load_out;

  logic                 in_acc;
  logic                 slot_free;
  logic                 skip_zero;
  logic [WIDE-1:0]      value_wide;
  logic [VB-1:0]        raw;
  logic                 raw_neg;
  logic [VB-1:0]        raw_mag;
  itoa_pkg::cell_ctrl_t ctrl;

  // Cell chain wiring: cell 0 is the least significant digit.
  logic [ND-1:0]      carry;
  logic [ND-1:0][3:0] digs;
  logic [3:0]         top_dig;

  // Only the low VALUE_BITS bits count; the top one is the sign.
  assign value_wide = {64'd0, value_i};
  assign raw        = value_wide[VB-1:0];
  assign raw_neg    = raw[VB-1];
  // Two's complement taken as unsigned: the most negative value is exact.
  assign raw_mag    = raw_neg ? (~raw + {{(VB-1){1'b0}}, 1'b1}) : raw;

  assign in_acc    = in_valid_i && in_ready_o;
  assign slot_free = !valid_q || out_ready_i;
  assign top_dig   = digs[ND-1];
  // Leading zero: drop it unless it is the only digit left (value zero).
  assign skip_zero = (top_dig == 4'd0) && (left_q > itoa_pkg::DIG_W'(1));

  for (genvar i = 0; i < ND; i++) begin : g_cell
    logic       cin;
    logic [3:0] din;
    if (i == 0) begin : g_bottom
      assign cin = mag_q[VB-1];
      assign din = 4'd0;
    end else begin : g_upper
      assign cin = carry[i-1];
      assign din = digs[i-1];
    end
    itoa_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .conv_in_i  (cin),
      .conv_out_o (carry[i]),
      .dig_in_i   (din),
      .dig_o      (digs[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_acc) state_d = itoa_pkg::ST_CONV;
      end
      itoa_pkg::ST_CONV: begin
        if (cnt_q == itoa_pkg::CNT_W'(1)) state_d = itoa_pkg::ST_SKIP;
      end
      itoa_pkg::ST_SKIP: begin
        if (!skip_zero) state_d = neg_q ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_SIGN: begin
        if (slot_free) state_d = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (slot_free && (left_q == itoa_pkg::DIG_W'(1))) state_d = itoa_pkg::ST_IDLE;
      end
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the FSM: cell control, input ready and output register load
  always_comb begin
    in_ready_o = 1'b0;
    ctrl       = '0;
    load_out   = 1'b0;
    char_d     = char_q;
    last_d     = last_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ctrl.clr   = in_valid_i;
      end
      itoa_pkg::ST_CONV: begin
        ctrl.conv = 1'b1;
      end
      itoa_pkg::ST_SKIP: begin
        ctrl.emit = skip_zero;
      end
      itoa_pkg::ST_SIGN: begin
        load_out = slot_free;
        char_d   = itoa_pkg::MINUS_CODE;
        last_d   = 1'b0;
      end
      itoa_pkg::ST_EMIT: begin
        load_out  = slot_free;
        ctrl.emit = slot_free;
        char_d    = itoa_pkg::DIGIT_BASE + {3'd0, top_dig};
        last_d    = (left_q == itoa_pkg::DIG_W'(1));
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
      if (in_acc) begin
        cnt_q <= itoa_pkg::CNT_W'(VB);
      end else if (ctrl.conv) begin
        cnt_q <= cnt_q - itoa_pkg::CNT_W'(1);
      end
      if (in_acc) begin
        left_q <= itoa_pkg::DIG_W'(ND);
      end else if (ctrl.emit) begin
        left_q <= left_q - itoa_pkg::DIG_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_q <= raw_mag;
      neg_q <= raw_neg;
    end else if (ctrl.conv) begin
      mag_q <= {mag_q[VB-2:0], 1'b0};
    end
    if (load_out) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign character_o = char_q;
  assign last_char_o = last_q;
  assign out_valid_o = valid_q;

`ifndef SYNTHESIS
  // The chain is wide enough: nothing ever carries out of the top cell.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.conv |-> !carry[ND-1])
    else $error("BCD chain overflow");

  // Digits reaching the output are valid BCD.
  a_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itoa_pkg::ST_EMIT) |-> (top_dig <= itoa_pkg::BCD_MAX))
    else $error("non-BCD digit emitted");

  // A loaded character is never lost: a stalled output holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !load_out)
    else $error("output register overwritten while stalled");

  // The last character of a number ends the transaction sequence.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && last_d) |=> (state_q == itoa_pkg::ST_IDLE))
    else $error("last character without return to idle");
`endif

endmodule
